@@ rtl/cga_pkg.sv @@
// Shared types and constants for the convolutional gridding accumulator.
// No dependencies; imported by every module of the block but cga_ram.
package cga_pkg;

	localparam int VIS_W  = 16;
	localparam int CELL_W = 32;
	localparam int SUP_W  = 4;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_GRID = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_READ
	} cga_state_t;

	// window walker control and status
	typedef struct packed {
		logic start;
		logic step;
	} cga_walk_ctl_t;

	typedef struct packed {
		logic in_grid;
		logic last;
	} cga_walk_sts_t;

endpackage

@@ rtl/convolutional_gridding_accumulator_core.sv @@
// Top level of the convolutional gridding accumulator: sequencer, grid and
// kernel RAMs, window walker and the shared complex MAC.
// Depends on cga_pkg, cga_ram, cga_walk, cga_cmac.
//
//  channel  direction  handshake            word
//  in       sink       in_valid / in_stall   opcode, centre, visibility, weight
//  out      source     out_valid / out_stall cell_re, cell_im
//  cfg      sink       cfg_we               cfg_wdata (support)
//
// Load words go in back to back. A read word waits for the output register.
// Grid word: walks all (2S+1)^2 taps, S the clamped support, then drains; it
// ends sooner when the last taps fall off the grid. One tap per cycle through
// the single complex MAC and the grid RAM read-modify-write path (3-stage:
// read, multiply, write). After reset a clearing pass zeroes the grid while
// in_stall is held high; cfg writes still land. A read result sits in the
// output register and out_stall only holds that register; the block stalls its
// input whenever it is not idle (clear, grid walk and drain, pending read).
module convolutional_gridding_accumulator_core import cga_pkg::*; #(
	parameter int GRID_DIM    = 256,
	parameter int MAX_SUPPORT = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               opcode,
	input  logic [7:0]               u_center,
	input  logic [7:0]               v_center,
	input  logic signed [VIS_W-1:0]  vis_re,
	input  logic signed [VIS_W-1:0]  vis_im,
	input  logic [4:0]               weight_row,
	input  logic [4:0]               weight_col,
	input  logic signed [VIS_W-1:0]  weight_re,
	input  logic signed [VIS_W-1:0]  weight_im,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CELL_W-1:0] cell_re,
	output logic signed [CELL_W-1:0] cell_im,
	// configuration
	input  logic                     cfg_we,
	input  logic [SUP_W-1:0]         cfg_wdata
);

	localparam int KDIM  = 2 * MAX_SUPPORT + 1;
	localparam int KAW   = $clog2(KDIM * KDIM);
	localparam int DEPTH = GRID_DIM * GRID_DIM;
	localparam int AW    = $clog2(DEPTH);

	cga_state_t state_q, state_d;

	logic [SUP_W-1:0]        support_q, s_eff;
	logic signed [VIS_W-1:0] vis_re_q, vis_im_q;
	logic                    rd_ok_q;
	logic [AW-1:0]           clr_q;
	logic                    clr_last;
	logic                    in_acc, out_load;

	logic                    out_valid_q;
	logic signed [CELL_W-1:0] cell_re_q, cell_im_q;

	// walker
	cga_walk_ctl_t           walk_ctl;
	cga_walk_sts_t           walk_sts;
	logic [AW-1:0]           walk_gaddr;
	logic [KAW-1:0]          walk_kaddr;

	// kernel RAM
	logic                    w_we, w_re;
	logic [KAW-1:0]          w_waddr;
	logic [2*VIS_W-1:0]      w_rdata;

	// grid RAM
	logic                    g_we, g_re;
	logic [AW-1:0]           g_waddr, g_raddr, rd_addr;
	logic [2*CELL_W-1:0]     g_wdata, g_rdata;

	// tap pipeline
	logic                    tap_s1, tap_s2;
	logic [AW-1:0]           gaddr_s1, gaddr_s2;
	logic signed [CELL_W-1:0] sum_re, sum_im;

	assign in_acc   = in_valid && !in_stall;
	assign s_eff    = (int'(support_q) > MAX_SUPPORT) ? SUP_W'(MAX_SUPPORT) : support_q;
	assign clr_last = (clr_q == AW'(DEPTH - 1));
	assign rd_addr  = AW'(v_center) * AW'(GRID_DIM) + AW'(u_center);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (opcode)
						OP_GRID: state_d = ST_RUN;
						OP_READ: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RUN: begin
				if (walk_sts.last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// leave only once the last write-back has landed
				if (!tap_s1 && !tap_s2) state_d = ST_IDLE;
			end
			ST_READ: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		walk_ctl.start = in_acc && (opcode == OP_GRID);
		walk_ctl.step  = (state_q == ST_RUN);
		w_re           = (state_q == ST_RUN);
		g_re           = (in_acc && (opcode == OP_READ)) ||
			((state_q == ST_RUN) && walk_sts.in_grid);
		g_raddr        = (state_q == ST_RUN) ? walk_gaddr : rd_addr;
		out_load       = (state_q == ST_READ) && (!out_valid_q || !out_stall);
	end

	// kernel load: rows/cols beyond the table are dropped
	assign w_we    = in_acc && (opcode == OP_LOAD) &&
		(int'(weight_row) < KDIM) && (int'(weight_col) < KDIM);
	assign w_waddr = KAW'(weight_row) * KAW'(KDIM) + KAW'(weight_col);

	// grid write: clearing pass or tap write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			g_we    = 1'b1;
			g_waddr = clr_q;
			g_wdata = '0;
		end else begin
			g_we    = tap_s2;
			g_waddr = gaddr_s2;
			g_wdata = {sum_re, sum_im};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			support_q   <= SUP_W'(3);
			clr_q       <= '0;
			tap_s1      <= 1'b0;
			tap_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) support_q <= cfg_wdata;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			tap_s1 <= (state_q == ST_RUN) && walk_sts.in_grid;
			tap_s2 <= tap_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc && (opcode == OP_READ)) begin
				rd_ok_q <= (int'(u_center) < GRID_DIM) && (int'(v_center) < GRID_DIM);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (walk_ctl.start) begin
			vis_re_q <= vis_re;
			vis_im_q <= vis_im;
		end
		gaddr_s1 <= walk_gaddr;
		gaddr_s2 <= gaddr_s1;
		if (out_load) begin
			cell_re_q <= rd_ok_q ? g_rdata[2*CELL_W-1:CELL_W] : '0;
			cell_im_q <= rd_ok_q ? g_rdata[CELL_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_re   = cell_re_q;
	assign cell_im   = cell_im_q;

	cga_walk #(
		.GRID_DIM    (GRID_DIM),
		.MAX_SUPPORT (MAX_SUPPORT)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (walk_ctl),
		.u_center  (u_center),
		.v_center  (v_center),
		.support   (s_eff),
		.sts       (walk_sts),
		.grid_addr (walk_gaddr),
		.k_addr    (walk_kaddr)
	);

	cga_ram #(
		.WIDTH (2 * VIS_W),
		.DEPTH (KDIM * KDIM)
	) u_kernel_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata ({weight_re, weight_im}),
		.re    (w_re),
		.raddr (walk_kaddr),
		.rdata (w_rdata)
	);

	cga_ram #(
		.WIDTH (2 * CELL_W),
		.DEPTH (DEPTH)
	) u_grid_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (g_re),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	cga_cmac u_cmac (
		.clk    (clk),
		.en     (tap_s1),
		.vis_re (vis_re_q),
		.vis_im (vis_im_q),
		.w_re   (w_rdata[2*VIS_W-1:VIS_W]),
		.w_im   (w_rdata[VIS_W-1:0]),
		.acc_re (g_rdata[2*CELL_W-1:CELL_W]),
		.acc_im (g_rdata[CELL_W-1:0]),
		.sum_re (sum_re),
		.sum_im (sum_im)
	);

`ifndef SYNTHESIS
	// no tap write-back may race the clearing pass
	a_no_tap_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!tap_s1 && !tap_s2))
		else $error("tap write-back during grid clear");

	// write-back stage is the registered read stage
	a_tap_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		tap_s2 |-> $past(tap_s1))
		else $error("tap write-back without a matching read");

	// a pending result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(cell_re_q) && $stable(cell_im_q)))
		else $error("pending result lost");

	// a read word always moves to the read state
	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (opcode == OP_READ)) |=> (state_q == ST_READ))
		else $error("read word not sequenced");
`endif

endmodule

@@ rtl/cga_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cga_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/cga_cmac.sv @@
// Shared complex multiply-accumulate unit: registered Q1.15 products, then
// floor shift by 15 and saturating add into the 32-bit cell parts.
// Depends on cga_pkg.
module cga_cmac import cga_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [VIS_W-1:0]  vis_re,
	input  logic signed [VIS_W-1:0]  vis_im,
	input  logic signed [VIS_W-1:0]  w_re,
	input  logic signed [VIS_W-1:0]  w_im,
	input  logic signed [CELL_W-1:0] acc_re,
	input  logic signed [CELL_W-1:0] acc_im,
	output logic signed [CELL_W-1:0] sum_re,
	output logic signed [CELL_W-1:0] sum_im
);

	localparam int PW = 2 * VIS_W;
	localparam int SW = PW + 1 - (VIS_W - 1);

	logic signed [PW-1:0]     p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [CELL_W-1:0] acc_re_s2, acc_im_s2;
	logic signed [PW:0]       re_full, im_full;
	logic signed [SW-1:0]     re_sh, im_sh;
	logic signed [CELL_W:0]   re_sum, im_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s2   <= vis_re * w_re;
			p_ii_s2   <= vis_im * w_im;
			p_ri_s2   <= vis_re * w_im;
			p_ir_s2   <= vis_im * w_re;
			acc_re_s2 <= acc_re;
			acc_im_s2 <= acc_im;
		end
	end

	always_comb begin
		re_full = (PW + 1)'(p_rr_s2) - (PW + 1)'(p_ii_s2);
		im_full = (PW + 1)'(p_ri_s2) + (PW + 1)'(p_ir_s2);
		// arithmetic shift is floor division by 2^15
		re_sh   = SW'(re_full >>> (VIS_W - 1));
		im_sh   = SW'(im_full >>> (VIS_W - 1));
		re_sum  = (CELL_W + 1)'(acc_re_s2) + (CELL_W + 1)'(re_sh);
		im_sum  = (CELL_W + 1)'(acc_im_s2) + (CELL_W + 1)'(im_sh);
		if (re_sum[CELL_W] != re_sum[CELL_W-1]) begin
			sum_re = re_sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
		end else begin
			sum_re = re_sum[CELL_W-1:0];
		end
		if (im_sum[CELL_W] != im_sum[CELL_W-1]) begin
			sum_im = im_sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
		end else begin
			sum_im = im_sum[CELL_W-1:0];
		end
	end

endmodule

@@ rtl/cga_walk.sv @@
// Window walker: steps through the (2S+1)^2 kernel taps, giving the kernel
// table address, the grid cell address and whether that cell lies on the grid.
// Depends on cga_pkg.
module cga_walk import cga_pkg::*; #(
	parameter int GRID_DIM    = 256,
	parameter int MAX_SUPPORT = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  cga_walk_ctl_t                                     ctl,
	input  logic [7:0]                                        u_center,
	input  logic [7:0]                                        v_center,
	input  logic [SUP_W-1:0]                                  support,
	output cga_walk_sts_t                                     sts,
	output logic [$clog2(GRID_DIM*GRID_DIM)-1:0]              grid_addr,
	output logic [$clog2((2*MAX_SUPPORT+1)*(2*MAX_SUPPORT+1))-1:0] k_addr
);

	localparam int KDIM = 2 * MAX_SUPPORT + 1;
	localparam int KW   = $clog2(KDIM);
	localparam int KAW  = $clog2(KDIM * KDIM);
	localparam int GW   = $clog2(GRID_DIM);
	localparam int AW   = $clog2(GRID_DIM * GRID_DIM);
	localparam int CW   = ((GW > 8) ? GW : 8) + 2;
	localparam logic signed [CW-1:0] ONE = 1;

	logic [SUP_W-1:0]     s_q;
	logic [7:0]           u_q;
	logic signed [CW-1:0] row_q, col_q, col_start;
	logic [KW-1:0]        kr_q, kc_q, span;
	logic [KAW-1:0]       k_q;

	assign span      = KW'({s_q, 1'b0});
	assign col_start = $signed(CW'(u_q)) - $signed(CW'(s_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q   <= '0;
			u_q   <= '0;
			row_q <= '0;
			col_q <= '0;
			kr_q  <= '0;
			kc_q  <= '0;
			k_q   <= '0;
		end else if (ctl.start) begin
			s_q   <= support;
			u_q   <= u_center;
			row_q <= $signed(CW'(v_center)) - $signed(CW'(support));
			col_q <= $signed(CW'(u_center)) - $signed(CW'(support));
			kr_q  <= '0;
			kc_q  <= '0;
			k_q   <= '0;
		end else if (ctl.step) begin
			if (kc_q == span) begin
				// wrap to the start of the next kernel row
				kc_q  <= '0;
				kr_q  <= kr_q + KW'(1);
				col_q <= col_start;
				row_q <= row_q + ONE;
				k_q   <= k_q + KAW'(KDIM) - KAW'(span);
			end else begin
				kc_q  <= kc_q + KW'(1);
				col_q <= col_q + ONE;
				k_q   <= k_q + KAW'(1);
			end
		end
	end

	always_comb begin
		sts.last    = (kr_q == span) && (kc_q == span);
		sts.in_grid = !row_q[CW-1] && !col_q[CW-1] &&
			(row_q < GRID_DIM) && (col_q < GRID_DIM);
		grid_addr   = AW'(row_q[GW-1:0]) * AW'(GRID_DIM) + AW'(col_q[GW-1:0]);
		k_addr      = k_q;
	end

endmodule

@@ tb/sv/convolutional_gridding_accumulator_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the convolutional gridding accumulator: watches the config
// port and both channels, keeps its own grid and kernel table, checks every read.
// Depends on cga_pkg.
module convolutional_gridding_accumulator_checker import cga_pkg::*; #(
	parameter int GRID_DIM    = 256,
	parameter int MAX_SUPPORT = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [1:0]               opcode,
	input  logic [7:0]               u_center,
	input  logic [7:0]               v_center,
	input  logic signed [VIS_W-1:0]  vis_re,
	input  logic signed [VIS_W-1:0]  vis_im,
	input  logic [4:0]               weight_row,
	input  logic [4:0]               weight_col,
	input  logic signed [VIS_W-1:0]  weight_re,
	input  logic signed [VIS_W-1:0]  weight_im,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [CELL_W-1:0] cell_re,
	input  logic signed [CELL_W-1:0] cell_im,
	input  logic                     cfg_we,
	input  logic [SUP_W-1:0]         cfg_wdata,
	output int                       mismatch_count,
	output int                       cells_due_count
);

	localparam int     KDIM     = 2 * MAX_SUPPORT + 1;
	localparam longint CELL_MAX = 64'sd2147483647;
	localparam longint CELL_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [CELL_W-1:0] re;
		logic signed [CELL_W-1:0] im;
	} cell_word_t;

	logic signed [CELL_W-1:0] grid_re [GRID_DIM*GRID_DIM];
	logic signed [CELL_W-1:0] grid_im [GRID_DIM*GRID_DIM];
	logic signed [VIS_W-1:0]  kern_re [KDIM*KDIM];
	logic signed [VIS_W-1:0]  kern_im [KDIM*KDIM];
	logic [SUP_W-1:0]         support_q;
	cell_word_t               cells_due_q [$];
	int                       mismatches;
	int                       cells_seen;

	function automatic logic signed [CELL_W-1:0] sat_add(logic signed [CELL_W-1:0] a,
			longint b);
		longint t;
		t = longint'(a) + b;
		if (t > CELL_MAX)
			return CELL_MAX[CELL_W-1:0];
		if (t < CELL_MIN)
			return CELL_MIN[CELL_W-1:0];
		return t[CELL_W-1:0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("cga_check: cell word %0d %0s got %0d expected %0d",
			cells_seen, what, got, want);
	endtask

	// walk the (2S+1)^2 window, skipping cells off the grid
	task automatic accumulate_window(logic [7:0] uc, logic [7:0] vc,
			logic signed [VIS_W-1:0] vr, logic signed [VIS_W-1:0] vi);
		int     s, dv, du, row, col, k, idx;
		longint wr, wi, pr, pi;
		s = (support_q > MAX_SUPPORT) ? MAX_SUPPORT : int'(support_q);
		for (dv = -s; dv <= s; dv++) begin
			row = int'(vc) + dv;
			if (row < 0 || row >= GRID_DIM)
				continue;
			for (du = -s; du <= s; du++) begin
				col = int'(uc) + du;
				if (col < 0 || col >= GRID_DIM)
					continue;
				k   = (dv + s) * KDIM + (du + s);
				wr  = longint'(kern_re[k]);
				wi  = longint'(kern_im[k]);
				// exact product, then floor shift
				pr  = (longint'(vr) * wr - longint'(vi) * wi) >>> 15;
				pi  = (longint'(vr) * wi + longint'(vi) * wr) >>> 15;
				idx = row * GRID_DIM + col;
				grid_re[idx] = sat_add(grid_re[idx], pr);
				grid_im[idx] = sat_add(grid_im[idx], pi);
			end
		end
	endtask

	task automatic check_cell();
		cell_word_t want;
		if (cells_due_q.size() == 0) begin
			report_mismatch("cell_re with no read pending", longint'(cell_re), 0);
			return;
		end
		want = cells_due_q.pop_front();
		if (cell_re !== want.re)
			report_mismatch("cell_re", longint'(cell_re), longint'(want.re));
		if (cell_im !== want.im)
			report_mismatch("cell_im", longint'(cell_im), longint'(want.im));
		cells_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_word_t c;
		if (!arst_n) begin
			for (int i = 0; i < GRID_DIM * GRID_DIM; i++) begin
				grid_re[i] = '0;
				grid_im[i] = '0;
			end
			for (int i = 0; i < KDIM * KDIM; i++) begin
				kern_re[i] = '0;
				kern_im[i] = '0;
			end
			support_q = 4'd3;
			cells_due_q.delete();
			mismatches = 0;
			cells_seen = 0;
			mismatch_count  <= 0;
			cells_due_count <= 0;
		end else begin
			if (cfg_we)
				support_q = cfg_wdata;
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_LOAD: begin
						// loads outside the table are dropped
						if (weight_row < KDIM && weight_col < KDIM) begin
							kern_re[weight_row * KDIM + weight_col] = weight_re;
							kern_im[weight_row * KDIM + weight_col] = weight_im;
						end
					end
					OP_GRID: accumulate_window(u_center, v_center, vis_re, vis_im);
					OP_READ: begin
						if (u_center < GRID_DIM && v_center < GRID_DIM) begin
							c.re = grid_re[v_center * GRID_DIM + u_center];
							c.im = grid_im[v_center * GRID_DIM + u_center];
						end else begin
							c = '0;
						end
						cells_due_q.push_back(c);
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_cell();
			mismatch_count  <= mismatches;
			cells_due_count <= cells_due_q.size();
		end
	end

endmodule

@@ tb/sv/convolutional_gridding_accumulator_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for convolutional_gridding_accumulator_core: clock, reset,
// word stimulus, output stalls and verdict. Depends on cga_pkg and the checker.
module convolutional_gridding_accumulator_core_tb;
	import cga_pkg::*;

	localparam int GRID_DIM    = 256;
	localparam int MAX_SUPPORT = 8;
	localparam int KDIM        = 2 * MAX_SUPPORT + 1;

	// opcode the block must ignore
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic signed [VIS_W-1:0] Q_MIN = 16'sh8000;
	localparam logic signed [VIS_W-1:0] Q_MAX = 16'sh7fff;

	// longest grid word walks a 17x17 window; give it some slack
	localparam int DRAIN_CYCLES = 400;
	// the clearing pass alone holds in_stall high without any progress
	localparam int WATCHDOG_LIMIT = 250000;
	localparam int LONG_HOLD = 3000;
	localparam int NUM_PHASES = 13;
	localparam int WORDS_PER_PHASE = 96;
	// support per random phase, phase 0 in the low nibble; 15 and 9 act as 8
	localparam logic [NUM_PHASES*SUP_W-1:0] SUPPORT_PLAN = {
		4'd3, 4'd9, 4'd2, 4'd6, 4'd1, 4'd0, 4'd4,
		4'd8, 4'd2, 4'd15, 4'd1, 4'd3, 4'd0
	};

	typedef struct packed {
		logic [1:0]              op;
		logic [7:0]              u;
		logic [7:0]              v;
		logic signed [VIS_W-1:0] vr;
		logic signed [VIS_W-1:0] vi;
		logic [4:0]              wrow;
		logic [4:0]              wcol;
		logic signed [VIS_W-1:0] wre;
		logic signed [VIS_W-1:0] wim;
	} in_word_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               opcode;
	logic [7:0]               u_center;
	logic [7:0]               v_center;
	logic signed [VIS_W-1:0]  vis_re;
	logic signed [VIS_W-1:0]  vis_im;
	logic [4:0]               weight_row;
	logic [4:0]               weight_col;
	logic signed [VIS_W-1:0]  weight_re;
	logic signed [VIS_W-1:0]  weight_im;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [CELL_W-1:0] cell_re;
	logic signed [CELL_W-1:0] cell_im;
	logic                     cfg_we;
	logic [SUP_W-1:0]         cfg_wdata;

	int mismatch_count;
	int cells_due_count;
	int idle_cycles;

	// sender asks for a long output hold by bumping hold_ticket
	int hold_ticket = 0;
	int hold_served = 0;
	bit sender_gaps;

	convolutional_gridding_accumulator_core #(
		.GRID_DIM    (GRID_DIM),
		.MAX_SUPPORT (MAX_SUPPORT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.u_center   (u_center),
		.v_center   (v_center),
		.vis_re     (vis_re),
		.vis_im     (vis_im),
		.weight_row (weight_row),
		.weight_col (weight_col),
		.weight_re  (weight_re),
		.weight_im  (weight_im),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_re    (cell_re),
		.cell_im    (cell_im),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	convolutional_gridding_accumulator_checker #(
		.GRID_DIM    (GRID_DIM),
		.MAX_SUPPORT (MAX_SUPPORT)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.u_center        (u_center),
		.v_center        (v_center),
		.vis_re          (vis_re),
		.vis_im          (vis_im),
		.weight_row      (weight_row),
		.weight_col      (weight_col),
		.weight_re       (weight_re),
		.weight_im       (weight_im),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cell_re         (cell_re),
		.cell_im         (cell_im),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.cells_due_count (cells_due_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 250);
	endfunction

	// Q1.15 value, with the extremes and the values around zero weighted up
	function automatic logic signed [VIS_W-1:0] pick_q15();
		case ($urandom_range(0, 11))
			0:       return Q_MIN;
			1:       return Q_MAX;
			2:       return -16'sd1;
			3:       return 16'sd0;
			default: return VIS_W'($urandom);
		endcase
	endfunction

	// grid coordinate: the borders (window clipping), a hot spot where
	// windows pile up, or anywhere
	function automatic logic [7:0] pick_coord();
		case ($urandom_range(0, 4))
			0:       return 8'($urandom_range(0, 9));
			1:       return 8'($urandom_range(246, 255));
			2, 3:    return 8'($urandom_range(120, 135));
			default: return 8'($urandom);
		endcase
	endfunction

	// fields a word does not use still carry random bits
	function automatic in_word_t random_word();
		in_word_t w;
		w.op   = 2'($urandom);
		w.u    = 8'($urandom);
		w.v    = 8'($urandom);
		w.vr   = VIS_W'($urandom);
		w.vi   = VIS_W'($urandom);
		w.wrow = 5'($urandom);
		w.wcol = 5'($urandom);
		w.wre  = VIS_W'($urandom);
		w.wim  = VIS_W'($urandom);
		return w;
	endfunction

	function automatic in_word_t word_load(logic [4:0] r, logic [4:0] c,
			logic signed [VIS_W-1:0] re, logic signed [VIS_W-1:0] im);
		in_word_t w;
		w      = random_word();
		w.op   = OP_LOAD;
		w.wrow = r;
		w.wcol = c;
		w.wre  = re;
		w.wim  = im;
		return w;
	endfunction

	function automatic in_word_t word_grid(logic [7:0] u, logic [7:0] v,
			logic signed [VIS_W-1:0] re, logic signed [VIS_W-1:0] im);
		in_word_t w;
		w    = random_word();
		w.op = OP_GRID;
		w.u  = u;
		w.v  = v;
		w.vr = re;
		w.vi = im;
		return w;
	endfunction

	function automatic in_word_t word_read(logic [7:0] u, logic [7:0] v);
		in_word_t w;
		w    = random_word();
		w.op = OP_READ;
		w.u  = u;
		w.v  = v;
		return w;
	endfunction

	// Offer one word and return right after the edge that takes it. in_valid
	// only drops when a gap is inserted, so it never toggles within a step.
	task automatic send_word(in_word_t w);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= w.op;
		u_center   <= w.u;
		v_center   <= w.v;
		vis_re     <= w.vr;
		vis_im     <= w.vi;
		weight_row <= w.wrow;
		weight_col <= w.wcol;
		weight_re  <= w.wre;
		weight_im  <= w.wim;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	// Block goes quiet: every read answered, then enough cycles for a
	// trailing grid word (no result of its own) to finish its window.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (cells_due_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_support(logic [SUP_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Output side: random stall runs, occasional long free-flowing stretches,
	// and on request one long hold so reads back up and in_stall rises.
	initial begin
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_ticket != hold_served) begin
				hold_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 19) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(100, 400)) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// Watchdog: any accepted word on either channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[convolutional_gridding_accumulator_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int             r, c, phase, counted, roll, span, off;
		logic [SUP_W-1:0] sup;
		logic [7:0]     last_u, last_v, ru, rv;
		in_word_t       w;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		opcode      <= OP_LOAD;
		u_center    <= '0;
		v_center    <= '0;
		vis_re      <= '0;
		vis_im      <= '0;
		weight_row  <= '0;
		weight_col  <= '0;
		weight_re   <= '0;
		weight_im   <= '0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		sender_gaps = 1'b1;
		last_u      = 8'd128;
		last_v      = 8'd128;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole kernel table first so no window ever touches an
		// unwritten weight. These go in once the clearing pass lets go.
		for (r = 0; r < KDIM; r++)
			for (c = 0; c < KDIM; c++)
				send_word(word_load(5'(r), 5'(c), pick_q15(), pick_q15()));

		// --- directed ---
		// reset support (3): window clipped at the left and bottom borders
		send_word(word_grid(8'd1, 8'd254, Q_MAX, Q_MIN));
		send_word(word_read(8'd0, 8'd255));
		send_word(word_read(8'd4, 8'd251));

		settle();
		write_support(4'd0);
		// largest positive real product, single-cell window at both corners
		send_word(word_load(5'd0, 5'd0, Q_MIN, Q_MAX));
		send_word(word_grid(8'd0, 8'd0, Q_MIN, Q_MIN));
		send_word(word_grid(8'd255, 8'd255, Q_MAX, Q_MAX));
		send_word(word_read(8'd0, 8'd0));
		send_word(word_read(8'd255, 8'd255));
		// tiny negative product must floor to -1, not truncate to 0
		send_word(word_load(5'd0, 5'd0, 16'sd1, 16'sd0));
		send_word(word_grid(8'd7, 8'd9, -16'sd1, 16'sd0));
		send_word(word_read(8'd7, 8'd9));
		// loads past the table end are dropped; weight (0,0) stays (1,0)
		send_word(word_load(5'd17, 5'd0, Q_MIN, Q_MIN));
		send_word(word_load(5'd0, 5'd31, Q_MIN, Q_MIN));
		send_word(word_load(5'd31, 5'd31, Q_MIN, Q_MIN));
		send_word(word_grid(8'd7, 8'd9, Q_MIN, 16'sd0));
		send_word(word_read(8'd7, 8'd9));
		// unused opcode with every field at all ones changes nothing
		w      = word_read(8'hff, 8'hff);
		w.op   = OP_NONE;
		w.vr   = -16'sd1;
		w.vi   = -16'sd1;
		w.wrow = 5'h1f;
		w.wcol = 5'h1f;
		w.wre  = -16'sd1;
		w.wim  = -16'sd1;
		send_word(w);
		send_word(word_read(8'd255, 8'd255));
		send_word(word_grid(8'd200, 8'd17, 16'sd0, 16'sd0));
		send_word(word_read(8'd200, 8'd17));

		settle();
		// support above the maximum clamps to a 17x17 window
		write_support(4'd15);
		send_word(word_grid(8'd0, 8'd0, Q_MAX, Q_MIN));
		send_word(word_grid(8'd255, 8'd0, Q_MIN, Q_MAX));
		send_word(word_read(8'd8, 8'd8));
		send_word(word_read(8'd247, 8'd8));
		send_word(word_read(8'd0, 8'd0));

		// --- random ---
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			sup = SUPPORT_PLAN[phase*SUP_W +: SUP_W];
			write_support(sup);
			span = ((sup > MAX_SUPPORT) ? MAX_SUPPORT : int'(sup)) + 1;
			// every fourth phase runs the sender flat out
			sender_gaps = (phase % 4 != 2);
			// one long output hold while words keep coming in
			if (phase == 1)
				hold_ticket++;
			counted = 0;
			while (counted < WORDS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 25) begin
					if ($urandom_range(0, 9) == 0) begin
						r = $urandom_range(0, 31);
						c = $urandom_range(0, 31);
					end else begin
						r = $urandom_range(0, KDIM - 1);
						c = $urandom_range(0, KDIM - 1);
					end
					send_word(word_load(5'(r), 5'(c), pick_q15(), pick_q15()));
					if (r < KDIM && c < KDIM)
						counted++;
				end else if (roll < 65) begin
					last_u = pick_coord();
					last_v = pick_coord();
					send_word(word_grid(last_u, last_v, pick_q15(), pick_q15()));
					counted++;
				end else if (roll < 95) begin
					// mostly inside or just past the last window
					if ($urandom_range(0, 3) != 0) begin
						off = $urandom_range(0, 2 * span);
						ru  = last_u + 8'(off - span);
						off = $urandom_range(0, 2 * span);
						rv  = last_v + 8'(off - span);
					end else begin
						ru = pick_coord();
						rv = pick_coord();
					end
					send_word(word_read(ru, rv));
					counted++;
				end else begin
					w    = random_word();
					w.op = OP_NONE;
					send_word(w);
				end
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("[convolutional_gridding_accumulator_core] OK");
		else
			$display("[convolutional_gridding_accumulator_core] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/cga_pkg.sv
rtl/cga_ram.sv
rtl/cga_cmac.sv
rtl/cga_walk.sv
rtl/convolutional_gridding_accumulator_core.sv
tb/sv/convolutional_gridding_accumulator_checker.sv
tb/sv/convolutional_gridding_accumulator_core_tb.sv
